// ===== sv/mbd_pkg.sv =====
// Shared types and constants for the multi-button debouncer.
// No dependencies; used by the register block, the button cell and the top level.
package mbd_pkg;

  // Fixed geometry
  localparam int BUTTONS     = 4;
  localparam int BTN_IDX_W   = $clog2(BUTTONS);
  localparam int QUERY_W     = 3;
  localparam int STAMP_W     = 32;
  localparam int LOCKOUT_W   = 16;
  localparam int COUNT_W     = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // Register map (word index = paddr[3:2])
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_ACTIVE_LOW_MASK = 2'd0;
  localparam logic [1:0] REG_LOCKOUT_MS      = 2'd1;
  localparam logic [1:0] REG_STABLE_READS    = 2'd2;

  // Register reset values
  localparam logic [BUTTONS-1:0]   RST_ACTIVE_LOW_MASK = 4'hf;
  localparam logic [LOCKOUT_W-1:0] RST_LOCKOUT_MS      = 16'd50;
  localparam logic [COUNT_W-1:0]   RST_STABLE_READS    = 8'd3;

  // Stream payload widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [BUTTONS-1:0]   active_low_mask;
    logic [LOCKOUT_W-1:0] lockout_ms;
    logic [COUNT_W-1:0]   stable_reads;
  } cfg_t;

  // Per-button result of one poll
  typedef struct packed {
    logic event_flag;
    logic debounced;
    logic sample;
  } btn_status_t;

endpackage

// ===== sv/mbd_cfg_regs.sv =====
// APB-style configuration registers for the multi-button debouncer.
// Depends on mbd_pkg for the register map, reset values and cfg_t.
module mbd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [mbd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output mbd_pkg::cfg_t                    cfg
);

  logic [mbd_pkg::BUTTONS-1:0]   active_low_mask_r;
  logic [mbd_pkg::LOCKOUT_W-1:0] lockout_ms_r;
  logic [mbd_pkg::COUNT_W-1:0]   stable_reads_r;
  logic                          wr_en;
  logic [1:0]                    reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_mask_r <= mbd_pkg::RST_ACTIVE_LOW_MASK;
      lockout_ms_r      <= mbd_pkg::RST_LOCKOUT_MS;
      stable_reads_r    <= mbd_pkg::RST_STABLE_READS;
    end else if (wr_en) begin
      unique case (reg_idx)
        mbd_pkg::REG_ACTIVE_LOW_MASK: active_low_mask_r <= cfg_pwdata[mbd_pkg::BUTTONS-1:0];
        mbd_pkg::REG_LOCKOUT_MS:      lockout_ms_r      <= cfg_pwdata[mbd_pkg::LOCKOUT_W-1:0];
        mbd_pkg::REG_STABLE_READS:    stable_reads_r    <= cfg_pwdata[mbd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero elsewhere
  always_comb begin
    unique case (reg_idx)
      mbd_pkg::REG_ACTIVE_LOW_MASK:
        cfg_prdata = {{(mbd_pkg::CFG_DATA_W-mbd_pkg::BUTTONS){1'b0}}, active_low_mask_r};
      mbd_pkg::REG_LOCKOUT_MS:
        cfg_prdata = {{(mbd_pkg::CFG_DATA_W-mbd_pkg::LOCKOUT_W){1'b0}}, lockout_ms_r};
      mbd_pkg::REG_STABLE_READS:
        cfg_prdata = {{(mbd_pkg::CFG_DATA_W-mbd_pkg::COUNT_W){1'b0}}, stable_reads_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  assign cfg.active_low_mask = active_low_mask_r;
  assign cfg.lockout_ms      = lockout_ms_r;
  assign cfg.stable_reads    = stable_reads_r;

endmodule

// ===== sv/mbd_button.sv =====
// One debounced button: lockout timer test, match counter and reported state.
// Depends on mbd_pkg for widths and btn_status_t.
module mbd_button (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [mbd_pkg::STAMP_W-1:0]     now_ms,
  input  logic                            raw_level,
  input  logic                            active_low,
  input  logic [mbd_pkg::LOCKOUT_W-1:0]   lockout_ms,
  input  logic [mbd_pkg::COUNT_W-1:0]     stable_reads,
  output mbd_pkg::btn_status_t            status
);

  logic                          sample_r, sample_nxt;
  logic [mbd_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic                          deb_r, deb_nxt;
  logic [mbd_pkg::STAMP_W-1:0]   stamp_r, stamp_nxt;
  logic [mbd_pkg::STAMP_W-1:0]   elapsed;
  logic                          locked;
  logic                          pressed;
  logic                          report;

  // Elapsed time wraps modulo 2^32
  assign elapsed = now_ms - stamp_r;
  assign locked  = elapsed < {{(mbd_pkg::STAMP_W-mbd_pkg::LOCKOUT_W){1'b0}}, lockout_ms};
  assign pressed = raw_level ^ active_low;

  // Count matching reads, report a settled change
  always_comb begin
    sample_nxt = sample_r;
    count_nxt  = count_r;
    deb_nxt    = deb_r;
    stamp_nxt  = stamp_r;
    report     = 1'b0;
    if (!locked) begin
      if (pressed == sample_r) begin
        if (count_r != mbd_pkg::COUNT_MAX) count_nxt = count_r + 1'b1;
      end else begin
        sample_nxt = pressed;
        count_nxt  = 8'd1;
      end
      if ((count_nxt >= stable_reads) && (pressed != deb_r)) begin
        report    = 1'b1;
        deb_nxt   = pressed;
        stamp_nxt = now_ms;
      end
    end
  end

  // Advance state once per processed poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= 1'b0;
      count_r  <= '0;
      deb_r    <= 1'b0;
      stamp_r  <= '0;
    end else if (step) begin
      sample_r <= sample_nxt;
      count_r  <= count_nxt;
      deb_r    <= deb_nxt;
      stamp_r  <= stamp_nxt;
    end
  end

  assign status.event_flag = report;
  assign status.debounced  = deb_nxt;
  assign status.sample     = sample_nxt;

endmodule

// ===== sv/multi_button_debouncer.sv =====
// Multi-button debouncer top level: input register, button cells, result register.
// Depends on mbd_pkg, mbd_cfg_regs and mbd_button.
// A poll waits in the input register; its result is held in the result register.
// Throughput: one poll per cycle unless out_tready stalls; the single-pass update of the
// button cells between the input and result registers sets that figure.
// Reset: synchronous, active low; clears the input valid flag, the result register and
// all button state, and loads the register defaults.
module multi_button_debouncer (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [31:0] now_ms, [35:32] raw_levels, [38:36] query_button, [39] zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mbd_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: [3:0] event_mask, [7:4] reported_levels, [8] query_pressed, [15:9] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mbd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [mbd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [mbd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  mbd_pkg::cfg_t                         cfg;
  mbd_pkg::btn_status_t                  status [mbd_pkg::BUTTONS];

  logic                                  in_valid_r;
  logic [mbd_pkg::STAMP_W-1:0]           now_r;
  logic [mbd_pkg::BUTTONS-1:0]           raw_r;
  logic [mbd_pkg::QUERY_W-1:0]           query_r;
  logic                                  out_valid_r;
  logic [mbd_pkg::BUTTONS-1:0]           event_r, event_nxt;
  logic [mbd_pkg::BUTTONS-1:0]           levels_r, levels_nxt;
  logic                                  qp_r, qp_nxt;
  logic [mbd_pkg::BUTTONS-1:0]           sample_vec;
  logic                                  advance;
  logic                                  in_xfer;

  mbd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Process the held poll when the result register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r   <= in_tdata[31:0];
      raw_r   <= in_tdata[35:32];
      query_r <= in_tdata[38:36];
    end
  end

  // Button cells
  for (genvar i = 0; i < mbd_pkg::BUTTONS; i++) begin : g_btn
    mbd_button u_btn (
      .clk          (clk),
      .rst_n        (rst_n),
      .step         (advance),
      .now_ms       (now_r),
      .raw_level    (raw_r[i]),
      .active_low   (cfg.active_low_mask[i]),
      .lockout_ms   (cfg.lockout_ms),
      .stable_reads (cfg.stable_reads),
      .status       (status[i])
    );
    assign event_nxt[i]  = status[i].event_flag;
    assign levels_nxt[i] = status[i].debounced;
    assign sample_vec[i] = status[i].sample;
  end

  // Query: out-of-range buttons read as not pressed
  always_comb begin
    if (query_r < mbd_pkg::QUERY_W'(mbd_pkg::BUTTONS)) begin
      qp_nxt = sample_vec[query_r[mbd_pkg::BTN_IDX_W-1:0]];
    end else begin
      qp_nxt = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= advance;
    end
  end

  // Result fields track the button state, so they clear with it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      event_r  <= '0;
      levels_r <= '0;
      qp_r     <= 1'b0;
    end else if (advance) begin
      event_r  <= event_nxt;
      levels_r <= levels_nxt;
      qp_r     <= qp_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, qp_r, levels_r, event_r};

  // A processed poll always lands in the result register
  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("processed poll did not produce a result");

  // An event flag implies the reported level flipped on that button
  a_event_flips: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> ((event_nxt & ~(levels_nxt ^ levels_r)) == '0))
    else $error("event flagged without a level change");

  // Reported levels hold while no poll is processed
  a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!advance && in_valid_r && out_valid_r) |=> $stable(levels_nxt) || advance)
    else $error("button state moved without a processed poll");

  // A held result is never overwritten while stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !advance)
    else $error("result register overwritten during stall");

endmodule

// ===== tb/sv/tb_multi_button_debouncer.sv =====
// Self-checking testbench for multi_button_debouncer: directed table, then randomized phases.
// Depends on mbd_pkg and the multi_button_debouncer RTL; polls stream in, reports stream out,
// and each report is checked against a local debounce predictor.
`timescale 1ns / 1ps

module tb_multi_button_debouncer;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES       = 8;
  localparam int LONG_HOLD    = 200;

  // Poll fields, last field in the lowest bits
  typedef struct packed {
    logic [2:0]  query;
    logic [3:0]  raw;
    logic [31:0] now;
  } poll_t;

  // Report fields, last field in the lowest bits
  typedef struct packed {
    logic       qp;
    logic [3:0] levels;
    logic [3:0] events;
  } report_t;

  typedef struct packed {
    logic    typed;
    report_t exp;
  } poll_note_t;

  typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_sel;
    logic [31:0] value;
    logic [31:0] now;
    logic [3:0]  raw;
    logic [2:0]  query;
    logic        typed;
    report_t     exp;
  } dir_row_t;

  localparam int DIR_ROWS = 28;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [mbd_pkg::IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [mbd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [mbd_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Register mirror
  logic [mbd_pkg::BUTTONS-1:0]   cur_mask    = mbd_pkg::RST_ACTIVE_LOW_MASK;
  logic [mbd_pkg::LOCKOUT_W-1:0] cur_lockout = mbd_pkg::RST_LOCKOUT_MS;
  logic [mbd_pkg::COUNT_W-1:0]   cur_stable  = mbd_pkg::RST_STABLE_READS;

  // Per-button debounce state mirror
  logic [mbd_pkg::BUTTONS-1:0] btn_sample = '0;
  logic [mbd_pkg::BUTTONS-1:0] btn_state  = '0;
  logic [mbd_pkg::COUNT_W-1:0] btn_count [mbd_pkg::BUTTONS];
  logic [mbd_pkg::STAMP_W-1:0] btn_stamp [mbd_pkg::BUTTONS];

  report_t    pending_reports [$];
  poll_note_t poll_notes [$];
  dir_row_t   dir_rows [DIR_ROWS];

  int  polls_sent = 0;
  int  reports_checked = 0;
  int  events_seen = 0;
  int  settings_written = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;
  bit  long_hold_req = 1'b0;

  multi_button_debouncer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the button mirror by one poll and return the report it produces
  function automatic report_t debounce_poll(poll_t p);
    report_t r;
    logic [31:0] elapsed;
    logic pressed;
    r = '0;
    for (int b = 0; b < mbd_pkg::BUTTONS; b++) begin
      elapsed = p.now - btn_stamp[b];
      if (elapsed >= {16'd0, cur_lockout}) begin
        pressed = p.raw[b] ^ cur_mask[b];
        if (pressed == btn_sample[b]) begin
          if (btn_count[b] != mbd_pkg::COUNT_MAX) btn_count[b] = btn_count[b] + 1'b1;
        end else begin
          btn_sample[b] = pressed;
          btn_count[b] = 8'd1;
        end
        if (btn_count[b] >= cur_stable && pressed != btn_state[b]) begin
          btn_state[b] = pressed;
          btn_stamp[b] = p.now;
          r.events[b] = 1'b1;
        end
      end
    end
    r.levels = btn_state;
    r.qp = (p.query < mbd_pkg::BUTTONS) ? btn_sample[p.query[1:0]] : 1'b0;
    return r;
  endfunction

  // Write a register, read it back and update the mirror
  task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (sel)
      mbd_pkg::REG_ACTIVE_LOW_MASK: cur_mask = value[mbd_pkg::BUTTONS-1:0];
      mbd_pkg::REG_LOCKOUT_MS:      cur_lockout = value[mbd_pkg::LOCKOUT_W-1:0];
      mbd_pkg::REG_STABLE_READS:    cur_stable = value[mbd_pkg::COUNT_W-1:0];
      default: ;
    endcase
    settings_written++;
    // back-to-back read of the same register
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    readback = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    case (sel)
      mbd_pkg::REG_ACTIVE_LOW_MASK: want = {28'd0, cur_mask};
      mbd_pkg::REG_LOCKOUT_MS:      want = {16'd0, cur_lockout};
      default:                      want = {24'd0, cur_stable};
    endcase
    if (readback !== want) begin
      $error("register %0d readback: expected %h, got %h", sel, want, readback);
      fail_count++;
    end
  endtask

  // Offer one poll after a random gap and hold it until the transfer
  task automatic send_poll(input logic [31:0] now, input logic [3:0] raw,
                           input logic [2:0] query, input logic typed, input report_t fixed);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    poll_notes.push_back('{typed, fixed});
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, query, raw, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    polls_sent++;
  endtask

  // Stop offering and wait until every sent poll has been reported
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (reports_checked != polls_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Receiver: random backpressure, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 31);
      end
    end
  end

  // Check reports first, then predict for the poll taken at this edge
  always @(posedge clk) begin : scoreboard
    report_t got;
    report_t want;
    poll_note_t note;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[8:0];
        if (pending_reports.size() == 0) begin
          $error("report with no poll outstanding: %h", got);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          reports_checked++;
          if (got.events !== want.events) begin
            $error("event_mask: expected %h, got %h", want.events, got.events);
            fail_count++;
          end
          if (got.levels !== want.levels) begin
            $error("reported_levels: expected %h, got %h", want.levels, got.levels);
            fail_count++;
          end
          if (got.qp !== want.qp) begin
            $error("query_pressed: expected %b, got %b", want.qp, got.qp);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        note = poll_notes.pop_front();
        want = debounce_poll(in_tdata[38:0]);
        if (note.typed) want = note.exp;
        events_seen += $countones(want.events);
        pending_reports.push_back(want);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0]  mask_val;
    logic [15:0] lock_val;
    logic [7:0]  stab_val;
    logic [31:0] t;
    logic [3:0]  level;
    logic [3:0]  raw;
    int          run_left [mbd_pkg::BUTTONS];
    int          hold_max;
    int          phase_polls;
    int          pick;

    for (int b = 0; b < mbd_pkg::BUTTONS; b++) begin
      btn_count[b] = '0;
      btn_stamp[b] = '0;
    end
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;

    // Directed table: kind, register, value, now, raw, query, typed, expected report
    // reset lockout covers every button at time zero
    dir_rows[0]  = '{ROW_POLL, 2'd0, 32'd0, 32'd0, 4'h0, 3'd0, 1'b1, 9'h000};
    dir_rows[1]  = '{ROW_POLL, 2'd0, 32'd0, 32'd49, 4'hf, 3'd7, 1'b1, 9'h000};
    // lockout boundary, then three low reads press every button
    dir_rows[2]  = '{ROW_POLL, 2'd0, 32'd0, 32'd50, 4'h0, 3'd0, 1'b0, 9'h000};
    dir_rows[3]  = '{ROW_POLL, 2'd0, 32'd0, 32'd51, 4'h0, 3'd3, 1'b0, 9'h000};
    dir_rows[4]  = '{ROW_POLL, 2'd0, 32'd0, 32'd52, 4'h0, 3'd4, 1'b0, 9'h000};
    // inside lockout after the press
    dir_rows[5]  = '{ROW_POLL, 2'd0, 32'd0, 32'd53, 4'hf, 3'd1, 1'b0, 9'h000};
    // time wraps: huge elapsed, then release
    dir_rows[6]  = '{ROW_POLL, 2'd0, 32'd0, 32'hffff_ffff, 4'hf, 3'd2, 1'b0, 9'h000};
    dir_rows[7]  = '{ROW_POLL, 2'd0, 32'd0, 32'd0, 4'hf, 3'd5, 1'b0, 9'h000};
    dir_rows[8]  = '{ROW_POLL, 2'd0, 32'd0, 32'd1, 4'hf, 3'd6, 1'b0, 9'h000};
    // active high, zero lockout, zero stable reads
    dir_rows[9]  = '{ROW_CFG, mbd_pkg::REG_ACTIVE_LOW_MASK, 32'h0, 32'd0, 4'h0, 3'd0,
                     1'b0, 9'h000};
    dir_rows[10] = '{ROW_CFG, mbd_pkg::REG_LOCKOUT_MS, 32'h0, 32'd0, 4'h0, 3'd0,
                     1'b0, 9'h000};
    dir_rows[11] = '{ROW_CFG, mbd_pkg::REG_STABLE_READS, 32'h0, 32'd0, 4'h0, 3'd0,
                     1'b0, 9'h000};
    dir_rows[12] = '{ROW_POLL, 2'd0, 32'd0, 32'd1, 4'hf, 3'd0, 1'b0, 9'h000};
    dir_rows[13] = '{ROW_POLL, 2'd0, 32'd0, 32'd1, 4'h0, 3'd1, 1'b0, 9'h000};
    dir_rows[14] = '{ROW_POLL, 2'd0, 32'd0, 32'd2, 4'h5, 3'd2, 1'b0, 9'h000};
    // widest lockout and count, mixed polarity
    dir_rows[15] = '{ROW_CFG, mbd_pkg::REG_STABLE_READS, 32'hff, 32'd0, 4'h0, 3'd0,
                     1'b0, 9'h000};
    dir_rows[16] = '{ROW_CFG, mbd_pkg::REG_LOCKOUT_MS, 32'hffff, 32'd0, 4'h0, 3'd0,
                     1'b0, 9'h000};
    dir_rows[17] = '{ROW_CFG, mbd_pkg::REG_ACTIVE_LOW_MASK, 32'ha, 32'd0, 4'h0, 3'd0,
                     1'b0, 9'h000};
    dir_rows[18] = '{ROW_POLL, 2'd0, 32'd0, 32'd3, 4'h5, 3'd3, 1'b0, 9'h000};
    dir_rows[19] = '{ROW_POLL, 2'd0, 32'd0, 32'h0001_0000, 4'h5, 3'd4, 1'b0, 9'h000};
    dir_rows[20] = '{ROW_POLL, 2'd0, 32'd0, 32'h0000_ffff, 4'ha, 3'd0, 1'b0, 9'h000};
    dir_rows[21] = '{ROW_POLL, 2'd0, 32'd0, 32'h8000_0000, 4'hf, 3'd7, 1'b0, 9'h000};
    // lockout window that straddles the time wrap
    dir_rows[22] = '{ROW_CFG, mbd_pkg::REG_LOCKOUT_MS, 32'd50, 32'd0, 4'h0, 3'd0,
                     1'b0, 9'h000};
    dir_rows[23] = '{ROW_CFG, mbd_pkg::REG_STABLE_READS, 32'd1, 32'd0, 4'h0, 3'd0,
                     1'b0, 9'h000};
    dir_rows[24] = '{ROW_CFG, mbd_pkg::REG_ACTIVE_LOW_MASK, 32'h0, 32'd0, 4'h0, 3'd0,
                     1'b0, 9'h000};
    dir_rows[25] = '{ROW_POLL, 2'd0, 32'd0, 32'hffff_fff0, 4'hf, 3'd0, 1'b0, 9'h000};
    dir_rows[26] = '{ROW_POLL, 2'd0, 32'd0, 32'h0000_0010, 4'h0, 3'd1, 1'b0, 9'h000};
    dir_rows[27] = '{ROW_POLL, 2'd0, 32'd0, 32'h0000_0022, 4'h0, 3'd2, 1'b0, 9'h000};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
      end else begin
        send_poll(dir_rows[i].now, dir_rows[i].raw, dir_rows[i].query,
                  dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    // Random phases, each with its own settings
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin mask_val = 4'hf; lock_val = 16'd0;     stab_val = 8'd255; end
        1: begin mask_val = 4'h0; lock_val = 16'hffff;  stab_val = 8'd1;   end
        default: begin
          mask_val = 4'($urandom_range(15));
          lock_val = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                              : 16'($urandom_range(30));
          stab_val = (ph == 5) ? 8'd0 : 8'($urandom_range(1, 8));
        end
      endcase
      write_reg(mbd_pkg::REG_ACTIVE_LOW_MASK, {28'd0, mask_val});
      write_reg(mbd_pkg::REG_LOCKOUT_MS, {16'd0, lock_val});
      write_reg(mbd_pkg::REG_STABLE_READS, {24'd0, stab_val});
      no_idle = (ph == 2);
      phase_polls = (ph == 0) ? 400 : 205;
      hold_max = 3 * stab_val + 6 + ((lock_val <= 30) ? lock_val : 0);
      t = $urandom();
      level = '0;
      for (int b = 0; b < mbd_pkg::BUTTONS; b++) run_left[b] = 0;

      for (int n = 0; n < phase_polls; n++) begin
        if (ph == 3 && n == 40) long_hold_req = 1'b1;
        // let the block run empty once mid-phase
        if (ph == 4 && n == 100) drain_results();
        // hold each button level for a run, then pick a new one
        for (int b = 0; b < mbd_pkg::BUTTONS; b++) begin
          if (run_left[b] == 0) begin
            level[b] = 1'($urandom_range(1));
            run_left[b] = (ph == 0) ? $urandom_range(255, 300) : $urandom_range(1, hold_max);
          end
          run_left[b]--;
        end
        raw = level;
        if (ph != 0 && $urandom_range(99) < 8) raw[$urandom_range(3)] = ~raw[$urandom_range(3)];
        // advance time: mostly small steps, some repeats, a few jumps anywhere
        pick = $urandom_range(99);
        if (pick < 5)
          t = $urandom();
        else if (pick >= 15)
          t = t + ((ph == 1) ? $urandom_range(40000) : $urandom_range(1, 4));
        send_poll(t, raw, 3'($urandom_range(7)), 1'b0, '0);
      end
    end

    drain_results();
    no_idle = 1'b0;
    repeat (4) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      fail_count++;
    end

    $display("Sent %0d polls over %0d register writes; %0d reports checked, %0d button events.",
             polls_sent, settings_written, reports_checked, events_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
